@@ rtl/core/sssp_pkg.sv @@
// Shared constants and types for the shortest path core.
`timescale 1ns / 1ps
package sssp_pkg;
   localparam int NODE_COUNT = 32;
   localparam int EDGE_COUNT = 64;
   localparam int NODE_W     = 5;
   localparam int EIDX_W     = $clog2(EDGE_COUNT);
   localparam int ECNT_W     = $clog2(EDGE_COUNT + 1);
   localparam int WEIGHT_W   = 16;
   localparam int DIST_W     = 21;
   localparam int EDGE_W     = 2 * NODE_W + WEIGHT_W;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                op;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WEIGHT_W-1:0] weight;
      logic [NODE_W-1:0]   source;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [DIST_W-1:0] distance;
      logic              reachable;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_EREAD,
      ST_RELAX,
      ST_EMIT
   } state_type;
endpackage

@@ rtl/core/sssp_req_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface sssp_req_if;
   import sssp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sssp_rsp_if;
   import sssp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/single_source_shortest_path_core.sv @@
// Dijkstra single-source shortest path core: edge RAM, per-node distance registers.
// Edge beats: accepted every cycle while idle and no response is pending, no results.
// Query: per reached node a pick scan over all nodes, an edge read state and a relax pass
//   over every stored edge (one edge per cycle from the RAM), then one last empty pick scan.
// Emit: one step per node index, each held while a beat waits on rsp.ready.
// Reset (synchronous) clears the edge count, present, settled and reached bits, the response valid and the FSM.
`timescale 1ns / 1ps
module single_source_shortest_path_core (
   input  logic clock,
   input  logic reset,
   sssp_req_if.sink   req,
   sssp_rsp_if.source rsp
);
   import sssp_pkg::*;

   state_type state_ff, state_in;

   logic [ECNT_W-1:0]     etotal_ff;
   logic [NODE_COUNT-1:0] present_ff, settled_ff, reached_ff;
   logic [DIST_W-1:0]     dist_ff [NODE_COUNT];
   logic [NODE_W-1:0]     src_ff, scan_ff, pick_ff;
   logic                  found_ff, src_ok_ff;
   logic [DIST_W-1:0]     pdist_ff;
   logic [ECNT_W-1:0]     eidx_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept, wr_en, edge_ok;
   logic [EDGE_W-1:0]     rd_data;
   logic [EIDX_W-1:0]     rd_addr;
   logic [NODE_W-1:0]     ea, eb, to;
   logic [WEIGHT_W-1:0]   ew;
   logic [DIST_W:0]       cand_sum;
   logic [DIST_W-1:0]     cand;
   logic                  do_relax, report, emit_go;

   assign accept  = req.valid && req.ready;
   assign edge_ok = etotal_ff < ECNT_W'(EDGE_COUNT);
   assign wr_en   = accept && req.data.op == OP_ADD && edge_ok;
   assign rd_addr = eidx_ff[EIDX_W-1:0];

   sssp_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_COUNT)) u_edges (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (etotal_ff[EIDX_W-1:0]),
      .wr_data ({req.data.node_a, req.data.node_b, req.data.weight}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign {ea, eb, ew} = rd_data;
   assign to       = (ea == pick_ff) ? eb : ea;
   assign cand_sum = {1'b0, pdist_ff} + (DIST_W + 1)'(ew);
   assign cand     = cand_sum[DIST_W] ? DIST_MAX : cand_sum[DIST_W-1:0];
   // both ends equal to pick (self loop) resolves to pick, which is settled
   assign do_relax = (ea == pick_ff || eb == pick_ff) && !settled_ff[to] &&
                     (!reached_ff[to] || cand < dist_ff[to]);
   assign report   = present_ff[scan_ff] || (src_ok_ff && scan_ff == src_ff);
   assign emit_go  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && req.data.op == OP_QUERY) state_in = ST_PICK;
         ST_PICK: begin
            if (scan_ff == NODE_W'(NODE_COUNT - 1))
               state_in = (found_ff || (reached_ff[scan_ff] && !settled_ff[scan_ff]))
                          ? ST_EREAD : ST_EMIT;
         end
         ST_EREAD: state_in = (etotal_ff == '0) ? ST_PICK : ST_RELAX;
         // eidx runs one ahead of the edge on rd_data
         ST_RELAX: if (eidx_ff == etotal_ff) state_in = ST_PICK;
         ST_EMIT:  if (emit_go && scan_ff == NODE_W'(NODE_COUNT - 1)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (state_ff == ST_EMIT && emit_go) rsp_valid_in = report;
   end

   always_comb begin
      rsp_in.node      = scan_ff;
      rsp_in.distance  = reached_ff[scan_ff] ? dist_ff[scan_ff] : '0;
      rsp_in.reachable = reached_ff[scan_ff];
      rsp_in.last      = (scan_ff == NODE_W'(NODE_COUNT - 1)) ||
                         ((present_ff >> (scan_ff + 1'b1)) == '0 &&
                          !(src_ff > scan_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         etotal_ff    <= '0;
         present_ff   <= '0;
         settled_ff   <= '0;
         reached_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               scan_ff  <= '0;
               found_ff <= 1'b0;
               if (wr_en) begin
                  etotal_ff  <= etotal_ff + 1'b1;
                  present_ff <= present_ff | (NODE_COUNT'(1) << req.data.node_a) |
                                (NODE_COUNT'(1) << req.data.node_b);
               end
               if (accept && req.data.op == OP_QUERY) begin
                  src_ff     <= req.data.source;
                  src_ok_ff  <= 1'b1;
                  settled_ff <= '0;
                  reached_ff <= NODE_COUNT'(1) << req.data.source;
                  dist_ff[req.data.source] <= '0;
               end
            end
            ST_PICK: begin
               if (reached_ff[scan_ff] && !settled_ff[scan_ff] &&
                   (!found_ff || dist_ff[scan_ff] < pdist_ff)) begin
                  pick_ff  <= scan_ff;
                  pdist_ff <= dist_ff[scan_ff];
                  found_ff <= 1'b1;
               end
               scan_ff <= scan_ff + 1'b1;
               eidx_ff <= '0;
            end
            ST_EREAD: begin
               settled_ff[pick_ff] <= 1'b1;
               found_ff <= 1'b0;
               scan_ff  <= '0;
               eidx_ff  <= eidx_ff + 1'b1;
            end
            ST_RELAX: begin
               if (do_relax) begin
                  dist_ff[to]    <= cand;
                  reached_ff[to] <= 1'b1;
               end
               eidx_ff <= eidx_ff + 1'b1;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  scan_ff <= scan_ff + 1'b1;
                  if (report) rsp_ff <= rsp_in;
               end
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RELAX && do_relax |=> reached_ff[$past(to)])
      else $error("relaxed node not marked reached");
   assert property (@(posedge clock) disable iff (reset)
      etotal_ff <= ECNT_W'(EDGE_COUNT))
      else $error("edge count overflow");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("request taken during query");
endmodule

@@ rtl/core/sssp_ram.sv @@
// Generic single-port write, single-port read RAM with registered read.
`timescale 1ns / 1ps
module sssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the shortest path core: random edge loads and queries.
`timescale 1ns / 1ps
module testbench;
   import sssp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sssp_req_if req_ch ();
   sssp_rsp_if rsp_ch ();

   single_source_shortest_path_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // graph mirror
   logic [NODE_W-1:0]   mir_a [EDGE_COUNT];
   logic [NODE_W-1:0]   mir_b [EDGE_COUNT];
   logic [WEIGHT_W-1:0] mir_len [EDGE_COUNT];
   int                  mir_edges;
   logic                mir_present [NODE_COUNT];

   req_type pending_reqs [$];
   rsp_type expected_dists [$];
   int      error_count;
   int      send_idle_pct;
   int      recv_stall_pct;
   bit      hold_off = 1'b0;
   event    hold_go;
   longint  cycle_count;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic queue_req(input req_type it);
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   // apply one accepted beat to the mirror, queue any expected distances
   task automatic predict_item(input req_type it);
      logic [DIST_W:0] dist_v [NODE_COUNT];
      logic            seen [NODE_COUNT];
      logic            done [NODE_COUNT];
      logic [DIST_W:0] cand;
      rsp_type         r;
      int              pick, lastpos, base, k;
      rsp_type         outs [$];
      if (it.op == OP_ADD) begin
         if (mir_edges < EDGE_COUNT) begin
            mir_a[mir_edges] = it.node_a;
            mir_b[mir_edges] = it.node_b;
            mir_len[mir_edges] = it.weight;
            mir_edges++;
            mir_present[it.node_a] = 1'b1;
            mir_present[it.node_b] = 1'b1;
         end
         return;
      end
      for (int i = 0; i < NODE_COUNT; i++) begin
         dist_v[i] = '0; seen[i] = 1'b0; done[i] = 1'b0;
      end
      seen[it.source] = 1'b1;
      for (int rnd = 0; rnd < NODE_COUNT; rnd++) begin
         pick = -1;
         for (int i = 0; i < NODE_COUNT; i++)
            if (seen[i] && !done[i] && (pick < 0 || dist_v[i] < dist_v[pick])) pick = i;
         if (pick < 0) break;
         done[pick] = 1'b1;
         for (int e = 0; e < mir_edges; e++) begin
            for (int s = 0; s < 2; s++) begin
               base = s ? int'(mir_a[e]) : int'(mir_b[e]);
               k = s ? int'(mir_b[e]) : int'(mir_a[e]);
               if (base == pick) begin
                  cand = dist_v[pick] + mir_len[e];
                  if (cand > DIST_MAX) cand = {1'b0, DIST_MAX};
                  if (!done[k] && (!seen[k] || cand < dist_v[k])) begin
                     dist_v[k] = cand; seen[k] = 1'b1;
                  end
               end
            end
         end
      end
      for (int i = 0; i < NODE_COUNT; i++) begin
         if (mir_present[i] || i == it.source) begin
            r.node = NODE_W'(i);
            r.distance = seen[i] ? dist_v[i][DIST_W-1:0] : '0;
            r.reachable = seen[i];
            r.last = 1'b0;
            outs.insert(outs.size(), r);
         end
      end
      lastpos = outs.size() - 1;
      if (lastpos >= 0) outs[lastpos].last = 1'b1;
      foreach (outs[i]) expected_dists.insert(expected_dists.size(), outs[i]);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_item(req_ch.data);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.data <= pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted in cycles here
   initial begin
      forever begin
         @(hold_go);
         @(posedge clock);
         hold_off <= 1'b1;
         repeat (400) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_dists.size() == 0) begin
               report($sformatf("unexpected beat node %0d", got.node));
            end else begin
               want = expected_dists.pop_front();
               if (got.node !== want.node)
                  report($sformatf("node %0d want %0d", got.node, want.node));
               if (got.distance !== want.distance)
                  report($sformatf("node %0d distance %0d want %0d", want.node,
                                   got.distance, want.distance));
               if (got.reachable !== want.reachable)
                  report($sformatf("node %0d reachable %0b", want.node, got.reachable));
               if (got.last !== want.last)
                  report($sformatf("node %0d last %0b", want.node, got.last));
            end
         end
         if (hold_off)
            rsp_ch.ready <= 1'b0;
         else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic req_type mk_edge(int a, int b, int w);
      req_type it;
      it = '0;
      it.op = OP_ADD; it.node_a = NODE_W'(a); it.node_b = NODE_W'(b);
      it.weight = WEIGHT_W'(w);
      it.source = NODE_W'($urandom);
      return it;
   endfunction

   function automatic req_type mk_query(int s);
      req_type it;
      it = '0;
      it.op = OP_QUERY; it.source = NODE_W'(s);
      it.node_a = NODE_W'($urandom); it.node_b = NODE_W'($urandom);
      it.weight = WEIGHT_W'($urandom);
      return it;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_dists.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      error_count = 0; send_idle_pct = 0; recv_stall_pct = 0;
      cycle_count = 0; mir_edges = 0;
      foreach (mir_present[i]) mir_present[i] = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, extremes, self loop, maximum weights
      queue_req(mk_query(0));
      queue_req(mk_query(31));
      queue_req(mk_edge(0, 31, 65535));
      queue_req(mk_edge(31, 30, 65535));
      queue_req(mk_edge(5, 5, 7));
      queue_req(mk_edge(1, 2, 0));
      queue_req(mk_query(0));
      queue_req(mk_query(5));
      queue_req(mk_query(17));
      for (int i = 0; i < 32; i++) queue_req(mk_edge(i, (i + 1) % 32, 65535));
      queue_req(mk_query(0));
      queue_req(mk_query(31));
      drain();

      // phases of idling; long receiver hold-off in the first
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 68 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 68 : 0;
         if (ph == 3) begin send_idle_pct = 10; recv_stall_pct = 10; end
         if (ph == 0) -> hold_go;
         for (int n = 0; n < 60; n++) begin
            if ($urandom_range(9) < 7)
               queue_req(mk_edge($urandom_range(31), $urandom_range(31),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(300)));
            else
               queue_req(mk_query($urandom_range(31)));
         end
         queue_req(mk_query($urandom_range(31)));
         drain();
      end
      // store is full now; extra edges are ignored
      queue_req(mk_edge(3, 4, 1));
      queue_req(mk_query(3));
      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule
